### rtl/cfd_pkg.sv
package cfd_pkg;

  localparam int FRAME_BYTES = 17;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] SUM_BYTES = POS_W'(16);
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(16);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = CFG_IDX_W'(1);

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'h55;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // command in the lowest bits, arg_third in the highest
  typedef struct packed {
    logic [31:0] arg_third;
    logic [31:0] arg_second;
    logic [31:0] arg_first;
    logic [7:0]  sequence_res;
    logic [7:0]  command;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

### rtl/command_frame_deframer.sv
// Command frame deframer. Takes one received byte per beat on the slave side and can
// accept a byte every cycle while the result queue has room. It hunts for the two header
// bytes, collects a fixed-length frame, checks the additive checksum of bytes 0..15
// against byte 16 and, on a match, puts the command, sequence and three little-endian
// argument words out as one beat on the master side. Failed frames give nothing.
// Results pass through a four-entry queue; s_tready drops only while that queue is full,
// so bytes are taken at one per cycle as long as results are drained.
// The header bytes are set through the write port: index 0 first byte, index 1 second.
module command_frame_deframer import cfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [RES_W-1:0]     m_tdata    // command, sequence_res, arg_first, arg_second,
                                          // arg_third
);

  push_t push;
  logic  space;
  logic  accept;

  assign s_tready = space;
  assign accept   = s_tvalid && space;

  cfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .push      (push)
  );

  cfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### rtl/cfd_front.sv
module cfd_front import cfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output push_t                push
);

  localparam logic [1:0] PHASE_IDLE      = 2'd0;
  localparam logic [1:0] PHASE_GOT_FIRST = 2'd1;
  localparam logic [1:0] PHASE_FILLING   = 2'd2;

  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [1:0]       phase;
  logic [POS_W-1:0] pos;
  logic [7:0]       sum;
  logic [7:0]       frame_store [FRAME_BYTES];
  logic [7:0]       check_byte;
  logic             frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RESET;
      header_second <= HEADER_SECOND_RESET;
      phase         <= PHASE_IDLE;
      pos           <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEADER_FIRST) begin
          header_first <= cfg_data;
        end else if (cfg_index == REG_HEADER_SECOND) begin
          header_second <= cfg_data;
        end
      end
      if (accept) begin
        case (phase)
          PHASE_IDLE: begin
            if (rx_byte == header_first) begin
              pos   <= POS_W'(1);
              phase <= PHASE_GOT_FIRST;
            end
          end
          PHASE_GOT_FIRST: begin
            if (rx_byte == header_second) begin
              pos   <= POS_W'(2);
              phase <= PHASE_FILLING;
            end else if (rx_byte == header_first) begin
              pos <= POS_W'(1);
            end else begin
              pos   <= '0;
              phase <= PHASE_IDLE;
            end
          end
          PHASE_FILLING: begin
            if (frame_end) begin
              pos   <= '0;
              phase <= PHASE_IDLE;
            end else begin
              pos <= pos + POS_W'(1);
            end
          end
          default: begin
            pos   <= '0;
            phase <= PHASE_IDLE;
          end
        endcase
      end
    end
  end

  // frame bytes and running sum, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PHASE_IDLE: begin
          if (rx_byte == header_first) begin
            frame_store[0] <= rx_byte;
            sum            <= rx_byte;
          end
        end
        PHASE_GOT_FIRST: begin
          if (rx_byte == header_second) begin
            frame_store[1] <= rx_byte;
            sum            <= sum + rx_byte;
          end else if (rx_byte == header_first) begin
            frame_store[0] <= rx_byte;
            sum            <= rx_byte;
          end
        end
        PHASE_FILLING: begin
          frame_store[pos] <= rx_byte;
          if (pos < SUM_BYTES) begin
            sum <= sum + rx_byte;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign frame_end  = (phase == PHASE_FILLING) && (pos == LAST_POS);
  assign check_byte = (pos == CHECK_POS) ? rx_byte : frame_store[CHECK_POS];

  always_comb begin
    push.valid            = accept && frame_end && (sum == check_byte);
    push.res.command      = frame_store[2];
    push.res.sequence_res = frame_store[3];
    push.res.arg_first    = {frame_store[7], frame_store[6], frame_store[5], frame_store[4]};
    push.res.arg_second   = {frame_store[11], frame_store[10], frame_store[9], frame_store[8]};
    push.res.arg_third    = {frame_store[15], frame_store[14], frame_store[13],
                             frame_store[12]};
  end

  a_push_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (phase == PHASE_FILLING) && (pos == LAST_POS))
    else $error("result pushed away from frame end");

  a_end_returns_idle: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> (phase == PHASE_IDLE) && (pos == '0))
    else $error("parser did not return to idle after frame end");

  a_fill_pos_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PHASE_FILLING) |-> (pos >= POS_W'(2)) && (pos <= LAST_POS))
    else $error("fill position out of range");

endmodule

### rtl/cfd_queue.sv
module cfd_queue import cfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             space,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [RES_W-1:0] m_tdata
);

  res_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign space    = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push.valid && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push.valid) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> space)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push.valid && !pop |=> count == $past(count) + (QPTR_W + 1)'(1))
    else $error("queue count did not follow push");

endmodule

### tb/sv/cfd_frame_checker.sv
`timescale 1ns / 100ps

module cfd_frame_checker import cfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // rx_byte
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [RES_W-1:0]     m_tdata,   // command, sequence_res, arg_first, arg_second,
                                          // arg_third
  output int                   fail_count,
  output int                   frames_due,
  output int                   frames_checked
);

  typedef enum logic [1:0] {
    HUNT      = 2'd0,
    GOT_FIRST = 2'd1,
    FILLING   = 2'd2
  } parse_e;

  logic [7:0] want_first = HEADER_FIRST_RESET;
  logic [7:0] want_second = HEADER_SECOND_RESET;
  parse_e     phase = HUNT;
  logic [4:0] pos = '0;
  logic [7:0] store [FRAME_BYTES];
  res_t       passed_frames [$];
  res_t       got;
  res_t       want;
  int         fails = 0;
  int         checked = 0;

  task automatic report(input string what, input logic [31:0] exp_val,
                        input logic [31:0] act_val);
    if (fails < 10) begin
      $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
    end
    fails++;
  endtask

  // additive checksum over bytes 0..15 against byte 16
  task automatic close_frame();
    logic [7:0] total;
    res_t       r;
    total = 8'h00;
    for (int i = 0; i < SUM_BYTES; i++) total += store[i];
    if (total == store[CHECK_POS]) begin
      r.command      = store[2];
      r.sequence_res = store[3];
      r.arg_first    = {store[7], store[6], store[5], store[4]};
      r.arg_second   = {store[11], store[10], store[9], store[8]};
      r.arg_third    = {store[15], store[14], store[13], store[12]};
      passed_frames.push_back(r);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (phase)
      HUNT: begin
        if (b == want_first) begin
          store[0] = b;
          pos      = 5'd1;
          phase    = GOT_FIRST;
        end
      end
      GOT_FIRST: begin
        if (b == want_second) begin
          store[1] = b;
          pos      = 5'd2;
          phase    = FILLING;
        end else if (b == want_first) begin
          store[0] = b;
          pos      = 5'd1;
        end else begin
          pos   = '0;
          phase = HUNT;
        end
      end
      FILLING: begin
        if (pos < FRAME_BYTES) store[pos] = b;
        pos = pos + 5'd1;
        if (pos >= FRAME_BYTES || pos < 5'd2) begin
          close_frame();
          pos   = '0;
          phase = HUNT;
        end
      end
      default: begin
        pos   = '0;
        phase = HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_first  = HEADER_FIRST_RESET;
      want_second = HEADER_SECOND_RESET;
      phase       = HUNT;
      pos         = '0;
      passed_frames.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata);
        if (passed_frames.size() == 0) begin
          report("beat with nothing expected, command", 32'h0, 32'(got.command));
        end else begin
          want = passed_frames.pop_front();
          if (got.command !== want.command) begin
            report("command", 32'(want.command), 32'(got.command));
          end
          if (got.sequence_res !== want.sequence_res) begin
            report("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
          end
          if (got.arg_first !== want.arg_first) report("arg_first", want.arg_first, got.arg_first);
          if (got.arg_second !== want.arg_second) begin
            report("arg_second", want.arg_second, got.arg_second);
          end
          if (got.arg_third !== want.arg_third) report("arg_third", want.arg_third, got.arg_third);
          checked++;
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata);
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER_FIRST:  want_first = cfg_data;
          REG_HEADER_SECOND: want_second = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count     <= fails;
    frames_due     <= passed_frames.size();
    frames_checked <= checked;
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import cfd_pkg::*;

  localparam int BODY_BYTES     = 14;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NO_SPLIT       = -1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef enum {BODY_RANDOM, BODY_ZERO, BODY_ONES, BODY_HEADERS} body_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [RES_W-1:0]     m_tdata;

  int fail_count;
  int frames_due;
  int frames_checked;

  int gap_pct = 14;
  int stall_pct = 14;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;

  logic [7:0] hdr_first = HEADER_FIRST_RESET;
  logic [7:0] hdr_second = HEADER_SECOND_RESET;
  logic [7:0] body [BODY_BYTES];

  always #4 clk = ~clk;

  command_frame_deframer dut (.*);

  cfd_frame_checker frame_check (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("** command_frame_deframer: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_byte(input logic [7:0] value);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_HEADER_FIRST) hdr_first = value;
    else if (idx == REG_HEADER_SECOND) hdr_second = value;
  endtask

  task automatic set_headers(input logic [7:0] first_val, input logic [7:0] second_val);
    settle();
    write_reg(REG_HEADER_FIRST, first_val);
    write_reg(REG_HEADER_SECOND, second_val);
    settings_used++;
  endtask

  task automatic fill_body(input body_e kind);
    for (int i = 0; i < BODY_BYTES; i++) begin
      case (kind)
        BODY_ZERO: body[i] = 8'h00;
        BODY_ONES: body[i] = 8'hFF;
        BODY_HEADERS: begin
          case ($urandom_range(0, 3))
            0: body[i] = hdr_first;
            1: body[i] = hdr_second;
            default: body[i] = 8'($urandom);
          endcase
        end
        default: body[i] = 8'($urandom);
      endcase
    end
  endtask

  // split_at: headers are rewritten before that frame byte goes out
  task automatic send_frame(input bit corrupt, input int split_at);
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] total;
    frame[0] = hdr_first;
    frame[1] = hdr_second;
    total    = hdr_first + hdr_second;
    for (int i = 0; i < BODY_BYTES; i++) begin
      frame[i + 2] = body[i];
      total += body[i];
    end
    if (corrupt) total += 8'($urandom_range(1, 255));
    frame[CHECK_POS] = total;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == split_at) begin
        settle();
        write_reg(REG_HEADER_FIRST, 8'($urandom));
        write_reg(REG_HEADER_SECOND, 8'($urandom));
        settings_used++;
      end
      push_byte(frame[i]);
    end
    frames_sent++;
  endtask

  task automatic send_broken();
    case ($urandom_range(0, 2))
      0: begin
        push_byte(hdr_first);
        push_byte(8'($urandom));
      end
      1: begin
        push_byte(hdr_first);
        fill_body(BODY_RANDOM);
        send_frame(1'b0, NO_SPLIT);
      end
      default: begin
        push_byte(hdr_first);
        push_byte(hdr_second);
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop;
    int pick;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        fill_body(BODY_RANDOM);
        send_frame(1'b0, NO_SPLIT);
      end else if (pick < 70) begin
        fill_body(BODY_HEADERS);
        send_frame(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : NO_SPLIT);
      end else if (pick < 80) begin
        fill_body(BODY_RANDOM);
        send_frame(1'b1, NO_SPLIT);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else begin
        send_broken();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset headers, field extremes
    fill_body(BODY_ZERO);
    send_frame(1'b0, NO_SPLIT);
    fill_body(BODY_ONES);
    send_frame(1'b0, NO_SPLIT);
    fill_body(BODY_RANDOM);
    send_frame(1'b1, NO_SPLIT);
    // header pattern inside the payload must not resync
    fill_body(BODY_HEADERS);
    send_frame(1'b0, NO_SPLIT);
    // stray byte after first header, then a repeated first header
    push_byte(hdr_first);
    push_byte(8'h00);
    push_byte(hdr_first);
    push_byte(hdr_first);
    fill_body(BODY_RANDOM);
    send_frame(1'b0, NO_SPLIT);
    // headers rewritten while the parser is mid-frame
    fill_body(BODY_RANDOM);
    send_frame(1'b0, 7);
    fill_body(BODY_RANDOM);
    send_frame(1'b0, 1);
    settle();
    write_reg(REG_SPARE_LO, 8'h00);
    write_reg(REG_SPARE_HI, 8'hFF);
    fill_body(BODY_RANDOM);
    send_frame(1'b0, NO_SPLIT);
    set_headers(8'h00, 8'hFF);
    fill_body(BODY_ZERO);
    send_frame(1'b0, NO_SPLIT);
    set_headers(8'hFF, 8'h00);
    fill_body(BODY_ONES);
    send_frame(1'b0, NO_SPLIT);
    // identical header bytes
    set_headers(8'h3C, 8'h3C);
    fill_body(BODY_RANDOM);
    send_frame(1'b0, NO_SPLIT);

    set_headers(HEADER_FIRST_RESET, HEADER_SECOND_RESET);
    random_traffic(110);
    set_headers(8'($urandom), 8'($urandom));
    random_traffic(90);

    // output held off while frames keep arriving back to back
    gap_pct = 0;
    hold_asks <= hold_asks + 1;
    repeat (10) begin
      fill_body(BODY_RANDOM);
      send_frame(1'b0, NO_SPLIT);
    end
    gap_pct = 14;

    // stretch with no idling on either side
    set_headers(8'($urandom), 8'($urandom));
    gap_pct = 0;
    stall_pct <= 0;
    random_traffic(120);
    gap_pct = 14;
    stall_pct <= 14;

    set_headers(8'($urandom), 8'($urandom));
    random_traffic(90);
    settle();

    $display("%0d bytes, %0d frames offered, %0d results checked, %0d header settings",
             bytes_sent, frames_sent, frames_checked, settings_used);
    $display("covered bad checksums, noise, broken headers, mid-frame header changes, hold-off");
    if (fail_count == 0 && frames_due == 0) begin
      $display("** command_frame_deframer: PASSED **");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, frames_due);
      $display("** command_frame_deframer: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cfd_pkg.sv
rtl/cfd_front.sv
rtl/cfd_queue.sv
rtl/command_frame_deframer.sv
tb/sv/cfd_frame_checker.sv
tb/sv/tb.sv
